>>> sv/sobel_pkg.sv
`default_nettype none

package sobel_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_EDGE_THRESHOLD = 2'd0,
    REG_GROUPS_PER_ROW = 2'd1,
    REG_ROWS_PER_FRAME = 2'd2
  } cfg_reg_t;

  // register widths and reset values
  localparam int THR_W  = 11;
  localparam int GPR_W  = 10;
  localparam int RPF_W  = 11;
  localparam logic [THR_W-1:0] THR_RESET = 11'd40;
  localparam logic [GPR_W-1:0] GPR_RESET = 10'd360;
  localparam logic [RPF_W-1:0] RPF_RESET = 11'd240;

  // stream payload widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_ROW_W  = 10;
  localparam int OUT_GRP_W  = 9;

  // 3x3 sobel with L1 magnitude; the centre pixel has zero weight
  function automatic logic sobel_edge(
    input logic [7:0]       al,
    input logic [7:0]       ac,
    input logic [7:0]       ar,
    input logic [7:0]       ml,
    input logic [7:0]       mr,
    input logic [7:0]       bl,
    input logic [7:0]       bc,
    input logic [7:0]       br,
    input logic [THR_W-1:0] thr
  );
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic        [11:0] ax;
    logic        [11:0] ay;
    logic        [12:0] mag;
    gx = ($signed({4'd0, al}) - $signed({4'd0, ar}))
       + (($signed({4'd0, ml}) - $signed({4'd0, mr})) <<< 1)
       + ($signed({4'd0, bl}) - $signed({4'd0, br}));
    gy = ($signed({4'd0, al}) + ($signed({4'd0, ac}) <<< 1) + $signed({4'd0, ar}))
       - ($signed({4'd0, bl}) + ($signed({4'd0, bc}) <<< 1) + $signed({4'd0, br}));
    ax = gx[11] ? 12'(-gx) : 12'(gx);
    ay = gy[11] ? 12'(-gy) : 12'(gy);
    mag = {1'b0, ax} + {1'b0, ay};
    return mag > {2'b00, thr};
  endfunction

endpackage

`default_nettype wire

>>> sv/sobel_edge_detector_packed_luma.sv
`default_nettype none

// Sobel edge detector on a raster of packed luma groups. One group (Y0..Y3)
// is taken per clock on the input stream; the block keeps the two previous
// rows in a single line memory (one entry per group, older and newer row side
// by side) and the previous group of three rows in a window register. The line
// memory entry is read at the edge that accepts a group; in the next cycle the
// group computes its two 3x3 Sobel bits from that entry and writes it back as
// it leaves that stage; the result for group g of centre row y is registered
// as group g+1 of row y+1 leaves. The sustained rate is one group per clock;
// the input stalls only while a result waits in the output register and the
// compute stage already holds the next group. Only interior rows and groups
// produce a result; tlast marks the last result of a frame.
module sobel_edge_detector_packed_luma #(
  parameter int MAX_GROUPS = 512,
  parameter int MAX_ROWS   = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [sobel_pkg::IN_DATA_W-1:0]    in_tdata,   // luma_first, luma_second,
                                                              // luma_third, luma_fourth
  input  wire logic                               in_tuser,   // frame_start
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [sobel_pkg::OUT_DATA_W-1:0]        out_tdata,  // out_row, out_group,
                                                              // edge_center, edge_next
  output logic                                    out_tlast,  // frame_done
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [sobel_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [sobel_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int GW  = $clog2(MAX_GROUPS);
  localparam int GCW = $clog2(MAX_GROUPS + 1);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RCW = $clog2(MAX_ROWS + 1);

  // configuration registers
  logic [sobel_pkg::THR_W-1:0] thr_r;
  logic [sobel_pkg::GPR_W-1:0] gpr_r;
  logic [sobel_pkg::RPF_W-1:0] rpf_r;

  // position of the next group
  logic [GW-1:0]  grp_pos_r, grp_pos_nxt;
  logic [RW-1:0]  row_pos_r, row_pos_nxt;

  // compute stage
  logic                        s1_valid_r;
  logic [31:0]                 s1_word_r;
  logic [GW-1:0]               s1_grp_r;
  logic [RW-1:0]               s1_row_r;
  logic                        s1_emit_r;
  logic                        s1_last_r;
  logic                        s1_adv;

  // line memory and read path
  logic [63:0] line_mem [MAX_GROUPS];
  logic [63:0] rd_data_r;
  logic [63:0] fwd_data_r;
  logic        fwd_r;
  logic [63:0] line_pair;
  logic [31:0] up_word;
  logic [31:0] mid_word;

  // previous group of rows above, middle and current
  logic [31:0] win_up_r, win_mid_r, win_cur_r;

  // output register
  logic                           out_valid_r;
  logic [sobel_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                           out_last_r;

  logic           in_acc;
  logic [GCW-1:0] gcount;
  logic [RCW-1:0] rcount;
  logic [GW-1:0]  c_raw, c_cur;
  logic [RW-1:0]  r_raw, r_cur;
  logic [GCW-1:0] c_inc;
  logic [RCW-1:0] r_inc;
  logic           emit0, last0;
  logic           e_center, e_next;
  logic [31:0]    row_m1, grp_m1;

  // clamped frame size
  always_comb begin
    if (gpr_r < 10'd3) begin
      gcount = GCW'(3);
    end else if (32'(gpr_r) > 32'(MAX_GROUPS)) begin
      gcount = GCW'(MAX_GROUPS);
    end else begin
      gcount = GCW'(gpr_r);
    end
    if (rpf_r < 11'd3) begin
      rcount = RCW'(3);
    end else if (32'(rpf_r) > 32'(MAX_ROWS)) begin
      rcount = RCW'(MAX_ROWS);
    end else begin
      rcount = RCW'(rpf_r);
    end
  end

  // handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // position of the accepted group and of the one after it
  always_comb begin
    c_raw = in_tuser ? '0 : grp_pos_r;
    r_raw = in_tuser ? '0 : row_pos_r;
    c_cur = (GCW'(c_raw) >= gcount) ? '0 : c_raw;
    r_cur = (RCW'(r_raw) >= rcount) ? '0 : r_raw;
    c_inc = GCW'(c_cur) + GCW'(1);
    r_inc = RCW'(r_cur) + RCW'(1);
    if (c_inc >= gcount) begin
      grp_pos_nxt = '0;
      row_pos_nxt = (r_inc >= rcount) ? '0 : r_inc[RW-1:0];
    end else begin
      grp_pos_nxt = c_inc[GW-1:0];
      row_pos_nxt = r_cur;
    end
    emit0 = (32'(r_cur) >= 32'd2) && (32'(c_cur) >= 32'd2);
    last0 = (RCW'(r_cur) == rcount - RCW'(1)) && (GCW'(c_cur) == gcount - GCW'(1));
  end

  // line memory: read at accept, write back when the group leaves the compute stage
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_grp_r] <= {mid_word, s1_word_r};
    end
    if (in_acc) begin
      rd_data_r <= line_mem[c_cur];
    end
  end

  // forward the write-back when the next group reads the same entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_r      <= s1_adv && (c_cur == s1_grp_r);
      fwd_data_r <= {mid_word, s1_word_r};
      s1_word_r  <= in_tdata;
      s1_grp_r   <= c_cur;
      s1_row_r   <= r_cur;
      s1_emit_r  <= emit0;
      s1_last_r  <= last0;
    end
  end

  assign line_pair = fwd_r ? fwd_data_r : rd_data_r;
  assign up_word   = line_pair[63:32];
  assign mid_word  = line_pair[31:0];

  // two sobel bits: centred on Y1 of the previous group and on Y0 of this one
  always_comb begin
    e_center = sobel_pkg::sobel_edge(win_up_r[7:0], win_up_r[15:8], win_up_r[23:16],
                                     win_mid_r[7:0], win_mid_r[23:16],
                                     win_cur_r[7:0], win_cur_r[15:8], win_cur_r[23:16],
                                     thr_r);
    e_next   = sobel_pkg::sobel_edge(win_up_r[31:24], up_word[7:0], up_word[15:8],
                                     win_mid_r[31:24], mid_word[15:8],
                                     win_cur_r[31:24], s1_word_r[7:0], s1_word_r[15:8],
                                     thr_r);
    row_m1   = 32'(s1_row_r) - 32'd1;
    grp_m1   = 32'(s1_grp_r) - 32'd1;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_data_r <= {3'b000, e_next, e_center,
                     grp_m1[sobel_pkg::OUT_GRP_W-1:0], row_m1[sobel_pkg::OUT_ROW_W-1:0]};
      out_last_r <= s1_last_r;
    end
  end

  // control state, window and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      grp_pos_r   <= '0;
      row_pos_r   <= '0;
      win_up_r    <= '0;
      win_mid_r   <= '0;
      win_cur_r   <= '0;
      thr_r       <= sobel_pkg::THR_RESET;
      gpr_r       <= sobel_pkg::GPR_RESET;
      rpf_r       <= sobel_pkg::RPF_RESET;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        grp_pos_r  <= grp_pos_nxt;
        row_pos_r  <= row_pos_nxt;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        win_up_r  <= up_word;
        win_mid_r <= mid_word;
        win_cur_r <= s1_word_r;
      end
      if (s1_adv && s1_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          sobel_pkg::REG_EDGE_THRESHOLD: thr_r <= cfg_wdata[sobel_pkg::THR_W-1:0];
          sobel_pkg::REG_GROUPS_PER_ROW: gpr_r <= cfg_wdata[sobel_pkg::GPR_W-1:0];
          sobel_pkg::REG_ROWS_PER_FRAME: rpf_r <= cfg_wdata[sobel_pkg::RPF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> sv/sobel_chk.sv
`default_nettype none

module sobel_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [sobel_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                             out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // the first row and the first group give no result
  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[9:0] != 10'd0) && (out_tdata[18:10] != 9'd0))
    else $error("result on a border row or group");

endmodule

bind sobel_edge_detector_packed_luma sobel_chk u_sobel_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

>>> test/testbench.sv
`default_nettype none

module testbench;

  localparam int GROUP_CAP   = 512;
  localparam int ROW_CAP     = 1024;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 8;

  typedef logic [sobel_pkg::OUT_ROW_W-1:0] row_t;
  typedef logic [sobel_pkg::OUT_GRP_W-1:0] grp_t;

  // one edge result as the block reports it
  typedef struct packed {
    row_t row;
    grp_t grp;
    logic center_bit;
    logic next_bit;
    logic frame_done;
  } edge_res_t;

  // directed stimulus table
  typedef enum bit {STEP_WRITE, STEP_GROUP} step_kind_t;
  typedef struct {
    step_kind_t           kind;
    sobel_pkg::cfg_reg_t  addr;   // write: register
    int                   value;  // write: register value
    logic [31:0]          word;   // groups: Y3..Y0
    logic                 sof;    // groups: frame start on the first one only
    int                   reps;   // groups: how many identical groups
    bit                   typed;  // groups: last one carries the result below
    edge_res_t            want;
  } plan_step_t;

  // 3x3 raster: one result per frame, at row 1 group 1
  plan_step_t plan [10] = '{
    '{STEP_WRITE, sobel_pkg::REG_GROUPS_PER_ROW, 0, 32'h0, 1'b0, 0, 1'b0, '0},
    '{STEP_WRITE, sobel_pkg::REG_ROWS_PER_FRAME, 0, 32'h0, 1'b0, 0, 1'b0, '0},
    '{STEP_GROUP, sobel_pkg::REG_EDGE_THRESHOLD, 0, 32'h0000_0000, 1'b1, 9, 1'b1,
      '{10'd1, 9'd1, 1'b0, 1'b0, 1'b1}},
    '{STEP_WRITE, sobel_pkg::REG_EDGE_THRESHOLD, 1020, 32'h0, 1'b0, 0, 1'b0, '0},
    // bright top row: magnitude equals the threshold, so no edge
    '{STEP_GROUP, sobel_pkg::REG_EDGE_THRESHOLD, 0, 32'hFFFF_FFFF, 1'b0, 3, 1'b0, '0},
    '{STEP_GROUP, sobel_pkg::REG_EDGE_THRESHOLD, 0, 32'h0000_0000, 1'b0, 6, 1'b1,
      '{10'd1, 9'd1, 1'b0, 1'b0, 1'b1}},
    '{STEP_WRITE, sobel_pkg::REG_EDGE_THRESHOLD, 1019, 32'h0, 1'b0, 0, 1'b0, '0},
    // stray group, then restart with a bright bottom row
    '{STEP_GROUP, sobel_pkg::REG_EDGE_THRESHOLD, 0, 32'h5A5A_A5A5, 1'b0, 1, 1'b0, '0},
    '{STEP_GROUP, sobel_pkg::REG_EDGE_THRESHOLD, 0, 32'h0000_0000, 1'b1, 6, 1'b0, '0},
    '{STEP_GROUP, sobel_pkg::REG_EDGE_THRESHOLD, 0, 32'hFFFF_FFFF, 1'b0, 3, 1'b1,
      '{10'd1, 9'd1, 1'b1, 1'b1, 1'b1}}
  };

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [sobel_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // luma_first, luma_second,
                                                     // luma_third, luma_fourth
  logic                             in_tuser = 1'b0; // frame_start
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [sobel_pkg::OUT_DATA_W-1:0] out_tdata;       // out_row, out_group,
                                                     // edge_center, edge_next
  logic                             out_tlast;       // frame_done
  logic                             cfg_we = 1'b0;
  sobel_pkg::cfg_reg_t              cfg_addr = sobel_pkg::REG_EDGE_THRESHOLD;
  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [sobel_pkg::THR_W-1:0] thr_reg;
  logic [sobel_pkg::GPR_W-1:0] gpr_reg;
  logic [sobel_pkg::RPF_W-1:0] rpf_reg;
  logic [31:0]      older_row [GROUP_CAP];
  logic [31:0]      newer_row [GROUP_CAP];
  logic [31:0]      win [3];
  int unsigned      row_pos;
  int unsigned      grp_pos;

  edge_res_t pending_edges [$];
  int        mismatches = 0;
  int        results_taken = 0;
  int        cycle_count = 0;
  int        send_calm = 0;
  logic [7:0] flat_level = 8'd128;

  sobel_edge_detector_packed_luma dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int lum(input logic [31:0] w, input int k);
    return int'(w[8*k +: 8]);
  endfunction

  // l1 gradient magnitude against the threshold, strictly greater
  function automatic bit edge_over(input int al, input int ac, input int ar,
                                   input int ml, input int mr,
                                   input int bl, input int bc, input int br);
    int gx;
    int gy;
    gx = (al - ar) + 2 * (ml - mr) + (bl - br);
    gy = (al + 2 * ac + ar) - (bl + 2 * bc + br);
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    return (gx + gy) > int'(thr_reg);
  endfunction

  // advance the raster by one group; returns 1 when it yields edge bits
  function automatic bit predict_edges(input logic [31:0] word, input logic sof,
                                       output edge_res_t res);
    int unsigned gcnt;
    int unsigned rcnt;
    int unsigned r;
    int unsigned c;
    logic [31:0] up;
    logic [31:0] mid;
    bit          hit;
    gcnt = (gpr_reg < 3) ? 3 : (gpr_reg > GROUP_CAP) ? GROUP_CAP : gpr_reg;
    rcnt = (rpf_reg < 3) ? 3 : (rpf_reg > ROW_CAP) ? ROW_CAP : rpf_reg;
    if (sof) begin
      row_pos = 0;
      grp_pos = 0;
    end
    r = row_pos;
    c = grp_pos;
    // positions left over from larger sizes fold back to zero
    if (c >= gcnt) c = 0;
    if (r >= rcnt) r = 0;
    up  = older_row[c];
    mid = newer_row[c];
    hit = (r >= 2 && c >= 2);
    res = '0;
    if (hit) begin
      res.row = row_t'(r - 1);
      res.grp = grp_t'(c - 1);
      res.center_bit = edge_over(lum(win[0], 0), lum(win[0], 1), lum(win[0], 2),
                                 lum(win[1], 0), lum(win[1], 2),
                                 lum(win[2], 0), lum(win[2], 1), lum(win[2], 2));
      res.next_bit = edge_over(lum(win[0], 3), lum(up, 0), lum(up, 1),
                               lum(win[1], 3), lum(mid, 1),
                               lum(win[2], 3), lum(word, 0), lum(word, 1));
      res.frame_done = (r == rcnt - 1 && c == gcnt - 1);
    end
    win[0] = up;
    win[1] = mid;
    win[2] = word;
    older_row[c] = mid;
    newer_row[c] = word;
    c++;
    if (c >= gcnt) begin
      c = 0;
      r++;
      if (r >= rcnt) r = 0;
    end
    row_pos = r;
    grp_pos = c;
    return hit;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // random content: noise, saturated bytes or a nearly flat patch
  function automatic logic [31:0] random_group();
    logic [31:0] w;
    int          k;
    w = $urandom();
    case ($urandom_range(0, 3))
      2: begin
        for (k = 0; k < 4; k++) w[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      3: begin
        for (k = 0; k < 4; k++) w[8*k +: 8] = flat_level + 8'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return w;
  endfunction

  // offer one group, predict its result once the transaction is taken
  task automatic offer_group(input logic [31:0] word, input logic sof,
                             input bit typed, input edge_res_t want);
    edge_res_t got;
    bit        hit;
    if (send_calm > 0) begin
      send_calm--;
    end else if ($urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end else if ($urandom_range(0, 99) == 0) begin
      send_calm = $urandom_range(40, 150);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= sof;
    do @(posedge clk); while (!in_tready);
    hit = predict_edges(word, sof, got);
    if (typed) pending_edges.push_back(want);
    else if (hit) pending_edges.push_back(got);
  endtask

  task automatic stream_raster(input int count, input bit first_sof, input bit noisy);
    logic sof;
    for (int i = 0; i < count; i++) begin
      sof = (i == 0) ? first_sof : (noisy && $urandom_range(0, 59) == 0);
      offer_group(random_group(), sof, 1'b0, '0);
    end
  endtask

  // stop offering and let every expected result come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input sobel_pkg::cfg_reg_t addr, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value[sobel_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      sobel_pkg::REG_EDGE_THRESHOLD: thr_reg = value[sobel_pkg::THR_W-1:0];
      sobel_pkg::REG_GROUPS_PER_ROW: gpr_reg = value[sobel_pkg::GPR_W-1:0];
      sobel_pkg::REG_ROWS_PER_FRAME: rpf_reg = value[sobel_pkg::RPF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    edge_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_taken++;
      if (pending_edges.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none got row %0d group %0d",
                 $time, out_tdata[9:0], out_tdata[18:10]);
        mismatches++;
      end else begin
        want = pending_edges.pop_front();
        check_field("out_row", want.row, out_tdata[9:0]);
        check_field("out_group", want.grp, out_tdata[18:10]);
        check_field("edge_center", want.center_bit, out_tdata[19]);
        check_field("edge_next", want.next_bit, out_tdata[20]);
        check_field("frame_done", want.frame_done, out_tlast);
      end
    end
  end

  // result side back-pressure, with one long hold-off to fill the block
  initial begin : result_ready
    bit held_off;
    int stall_left;
    int calm_left;
    held_off   = 1'b0;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk);
      if (!held_off && results_taken >= 40) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        else if ($urandom_range(0, 149) == 0) calm_left = $urandom_range(50, 200);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int thr;
    int gpr;
    int rpf;
    thr_reg = sobel_pkg::THR_RESET;
    gpr_reg = sobel_pkg::GPR_RESET;
    rpf_reg = sobel_pkg::RPF_RESET;
    win     = '{32'h0, 32'h0, 32'h0};
    row_pos = 0;
    grp_pos = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        drain_results();
        write_reg(plan[i].addr, plan[i].value);
      end else begin
        for (int n = 0; n < plan[i].reps; n++)
          offer_group(plan[i].word, plan[i].sof && n == 0,
                      plan[i].typed && n == plan[i].reps - 1, plan[i].want);
      end
    end
    drain_results();

    // random small rasters, new setting each phase
    for (int p = 0; p < 10; p++) begin
      thr = (p == 0) ? 0 : (p == 1) ? 2047 : $urandom_range(0, 700);
      gpr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      rpf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      flat_level = 8'($urandom_range(0, 252));
      write_reg(sobel_pkg::REG_EDGE_THRESHOLD, thr);
      write_reg(sobel_pkg::REG_GROUPS_PER_ROW, gpr);
      write_reg(sobel_pkg::REG_ROWS_PER_FRAME, rpf);
      stream_raster($urandom_range(28, 46), 1'b1, 1'b1);
      drain_results();
    end

    // shrink the row under a frame in flight: group position folds to 0
    write_reg(sobel_pkg::REG_EDGE_THRESHOLD, $urandom_range(50, 400));
    write_reg(sobel_pkg::REG_GROUPS_PER_ROW, 12);
    write_reg(sobel_pkg::REG_ROWS_PER_FRAME, 8);
    stream_raster(5 * 12 + 9, 1'b1, 1'b0);
    drain_results();
    write_reg(sobel_pkg::REG_GROUPS_PER_ROW, 5);
    stream_raster(3 * 5 + 6 * 5, 1'b0, 1'b0);
    drain_results();
    // now shrink the frame below the current row: row position folds to 0
    write_reg(sobel_pkg::REG_ROWS_PER_FRAME, 4);
    stream_raster(2 * 4 * 5, 1'b0, 1'b0);
    drain_results();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
